// File: rtl/isaac_pkg.sv
`timescale 1ns / 1ps

package isaac_pkg;

    localparam int unsigned LOG2_WORDS_DEF = 8;
    localparam logic [31:0] GOLDEN = 32'h9e3779b9;

    localparam int unsigned CMD_W  = 2;
    localparam int unsigned IDX_W  = 8;
    localparam int unsigned WORD_W = 32;

    typedef enum logic [1:0] {
        CMD_SEED = 2'd0,
        CMD_INIT = 2'd1,
        CMD_NEXT = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    // Queued job from front to back.
    typedef struct packed {
        cmd_t              cmd;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] word;
        logic              seeded;
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCR,
        ST_FLD,
        ST_FADD,
        ST_FMIX,
        ST_FWR,
        ST_GRD,
        ST_GRD2,
        ST_GWR,
        ST_GRD3,
        ST_GFIN,
        ST_NRD,
        ST_NOUT
    } bstate_t;

    // One step of the eight-word scramble; step 0..7.
    // Step s: v[s] ^= shifted v[s+1]; v[s+3] += v[s]; v[s+1] += v[s+2].
    function automatic logic [255:0] scr_step(input logic [255:0] vin, input logic [2:0] s);
        logic [31:0] v [8];
        logic [31:0] p, q, r, sh;
        logic [255:0] vo;
        for (int k = 0; k < 8; k++) v[k] = vin[32*k +: 32];
        p = v[s];
        q = v[3'(s + 3'd1)];
        r = v[3'(s + 3'd2)];
        case (s)
            3'd0: sh = q << 11;
            3'd1: sh = q >> 2;
            3'd2: sh = v[3] << 8;
            3'd3: sh = v[4] >> 16;
            3'd4: sh = v[5] << 10;
            3'd5: sh = v[6] >> 4;
            3'd6: sh = v[7] << 8;
            default: sh = v[0] >> 9;
        endcase
        p = p ^ sh;
        v[s] = p;
        v[3'(s + 3'd3)] = v[3'(s + 3'd3)] + p;
        v[3'(s + 3'd1)] = q + r;
        for (int k = 0; k < 8; k++) vo[32*k +: 32] = v[k];
        return vo;
    endfunction

endpackage

// File: rtl/isaac_front.sv
`timescale 1ns / 1ps

// Accepts words, drops unused codes, queues jobs.
module isaac_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,
    output logic                 q_valid,
    input  logic                 q_take,
    output isaac_pkg::job_t      q_job
);

    isaac_pkg::job_t mem_reg [2];
    logic [1:0] wp_reg, rp_reg;
    logic [1:0] wp_next, rp_next;
    logic       push;
    isaac_pkg::job_t job_in;

    assign job_in.cmd    = isaac_pkg::cmd_t'(s_tdata[1:0]);
    assign job_in.idx    = s_tdata[9:2];
    assign job_in.word   = s_tdata[41:10];
    assign job_in.seeded = s_tdata[42];

    assign s_tready = (wp_reg - rp_reg) != 2'd2;
    assign push     = s_tvalid && s_tready && job_in.cmd != isaac_pkg::CMD_NONE;
    assign q_valid  = wp_reg != rp_reg;
    assign q_job    = mem_reg[rp_reg[0]];
    assign wp_next  = push ? wp_reg + 2'd1 : wp_reg;
    assign rp_next  = (q_take && q_valid) ? rp_reg + 2'd1 : rp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg[0]] <= job_in;
        end
    end

endmodule

// File: rtl/isaac_back.sv
`timescale 1ns / 1ps

// Sequencer over the two state memories.
module isaac_back
#(
    parameter int unsigned LOG2_WORDS = isaac_pkg::LOG2_WORDS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_take,
    input  isaac_pkg::job_t      q_job,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata
);

    localparam int unsigned N  = 1 << LOG2_WORDS;
    localparam int unsigned AW = LOG2_WORDS;

    logic [31:0] rmem [N];
    logic [31:0] mmem [N];

    isaac_pkg::bstate_t st_reg, st_next;
    isaac_pkg::job_t    job_reg;
    logic [255:0] v_reg, v_next;
    logic [4:0]   sc_reg, sc_next;     // scramble step counter
    logic [AW:0]  i_reg, i_next;       // word index
    logic [2:0]   k_reg, k_next;
    logic         pass_reg, pass_next;
    logic [31:0]  a_reg, a_next, b_reg, b_next, cnt_reg, cnt_next;
    logic [31:0]  x_reg, x_next, y_reg, y_next;
    logic [AW:0]  left_reg, left_next;
    logic [31:0]  out_reg, out_next;
    logic         ov_reg, ov_next;

    // memory ports
    logic          rwe, mwe;
    logic [AW-1:0] rwa, mwa, rra, mra;
    logic [31:0]   rwd, mwd, rrd, mrd;

    always_ff @(posedge clk)
    begin
        if (rwe) rmem[rwa] <= rwd;
        if (mwe) mmem[mwa] <= mwd;
        rrd <= rmem[rra];
        mrd <= mmem[mra];
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= isaac_pkg::ST_IDLE;
            a_reg    <= '0;
            b_reg    <= '0;
            cnt_reg  <= '0;
            left_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            cnt_reg  <= cnt_next;
            left_reg <= left_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= (q_take) ? q_job : job_reg;
        v_reg    <= v_next;
        sc_reg   <= sc_next;
        i_reg    <= i_next;
        k_reg    <= k_next;
        pass_reg <= pass_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        out_reg  <= out_next;
    end

    logic [AW-1:0] iw;
    logic [31:0]   t, a_mix;
    assign iw = i_reg[AW-1:0];

    always_comb
    begin
        case (iw[1:0])
            2'd0:    t = a_reg << 13;
            2'd1:    t = a_reg >> 6;
            2'd2:    t = a_reg << 2;
            default: t = a_reg >> 16;
        endcase
        a_mix = (a_reg ^ t) + mrd;
    end

    always_comb
    begin
        st_next = st_reg; v_next = v_reg; sc_next = sc_reg; i_next = i_reg;
        k_next = k_reg; pass_next = pass_reg; a_next = a_reg; b_next = b_reg;
        cnt_next = cnt_reg; x_next = x_reg; y_next = y_reg; left_next = left_reg;
        out_next = out_reg; ov_next = ov_reg;
        q_take = 1'b0;
        rwe = 1'b0; mwe = 1'b0; rwa = iw; mwa = iw; rwd = '0; mwd = '0;
        rra = iw; mra = iw;
        if (ov_reg && m_tready) ov_next = 1'b0;
        case (st_reg)
            isaac_pkg::ST_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    q_take = 1'b1;
                    case (q_job.cmd)
                        isaac_pkg::CMD_SEED:
                        begin
                            if (32'(q_job.idx) < N)
                            begin
                                rwe = 1'b1;
                                rwa = AW'(q_job.idx);
                                rwd = q_job.word;
                            end
                        end
                        isaac_pkg::CMD_INIT:
                        begin
                            a_next = '0; b_next = '0; cnt_next = '0;
                            v_next = {8{isaac_pkg::GOLDEN}};
                            sc_next = '0; i_next = '0; pass_next = 1'b0;
                            st_next = isaac_pkg::ST_SCR;
                        end
                        isaac_pkg::CMD_NEXT:
                        begin
                            if (left_reg != '0)
                            begin
                                left_next = left_reg - 1'b1;
                                st_next = isaac_pkg::ST_NRD;
                            end
                            else
                            begin
                                left_next = (AW+1)'(N - 1);
                                cnt_next = cnt_reg + 32'd1;
                                b_next = b_reg + cnt_reg + 32'd1;
                                i_next = '0;
                                st_next = isaac_pkg::ST_GRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // four scrambles of the golden words, one step a cycle
            isaac_pkg::ST_SCR:
            begin
                v_next = isaac_pkg::scr_step(v_reg, sc_reg[2:0]);
                sc_next = sc_reg + 5'd1;
                if (sc_reg == 5'd31)
                begin
                    k_next = '0;
                    st_next = job_reg.seeded ? isaac_pkg::ST_FLD : isaac_pkg::ST_FMIX;
                    sc_next = '0;
                end
            end
            // read eight source words and add them in
            isaac_pkg::ST_FLD:
            begin
                rra = AW'(i_reg + k_reg);
                mra = AW'(i_reg + k_reg);
                st_next = isaac_pkg::ST_FADD;
            end
            isaac_pkg::ST_FADD:
            begin
                v_next[32*k_reg +: 32] = v_reg[32*k_reg +: 32] + (pass_reg ? mrd : rrd);
                k_next = k_reg + 3'd1;
                st_next = (k_reg == 3'd7) ? isaac_pkg::ST_FMIX : isaac_pkg::ST_FLD;
            end
            isaac_pkg::ST_FMIX:
            begin
                v_next = isaac_pkg::scr_step(v_reg, sc_reg[2:0]);
                sc_next = sc_reg + 5'd1;
                if (sc_reg == 5'd7)
                begin
                    sc_next = '0;
                    k_next = '0;
                    st_next = isaac_pkg::ST_FWR;
                end
            end
            isaac_pkg::ST_FWR:
            begin
                mwe = 1'b1;
                mwa = AW'(i_reg + k_reg);
                mwd = v_reg[32*k_reg +: 32];
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd7)
                begin
                    i_next = i_reg + (AW+1)'(8);
                    if (i_reg + (AW+1)'(8) == (AW+1)'(N))
                    begin
                        i_next = '0;
                        if (job_reg.seeded && !pass_reg)
                        begin
                            pass_next = 1'b1;
                            st_next = isaac_pkg::ST_FLD;
                        end
                        else
                        begin
                            left_next = (AW+1)'(N);
                            cnt_next = cnt_reg + 32'd1;
                            b_next = b_reg + cnt_reg + 32'd1;
                            st_next = isaac_pkg::ST_GRD;
                        end
                    end
                    else
                    begin
                        st_next = job_reg.seeded ? isaac_pkg::ST_FLD : isaac_pkg::ST_FMIX;
                    end
                end
            end
            // batch: read x and the far word
            isaac_pkg::ST_GRD:
            begin
                mra = iw;
                st_next = isaac_pkg::ST_GRD2;
            end
            isaac_pkg::ST_GRD2:
            begin
                x_next = mrd;
                mra = iw ^ AW'(N / 2);
                st_next = isaac_pkg::ST_GWR;
            end
            isaac_pkg::ST_GWR:
            begin
                a_next = a_mix;
                mra = x_reg[AW+1:2];
                st_next = isaac_pkg::ST_GRD3;
            end
            isaac_pkg::ST_GRD3:
            begin
                y_next = mrd + a_reg + b_reg;
                mwe = 1'b1;
                mwd = mrd + a_reg + b_reg;
                st_next = isaac_pkg::ST_GFIN;
            end
            isaac_pkg::ST_GFIN:
            begin
                mra = y_reg[2*AW+1:AW+2];
                st_next = isaac_pkg::ST_NOUT;
                sc_next = 5'd1; // marks batch step
            end
            isaac_pkg::ST_NRD:
            begin
                rra = left_reg[AW-1:0];
                sc_next = '0;
                st_next = isaac_pkg::ST_NOUT;
            end
            isaac_pkg::ST_NOUT:
            begin
                if (sc_reg[0])
                begin
                    b_next = mrd + x_reg;
                    rwe = 1'b1;
                    rwd = mrd + x_reg;
                    i_next = i_reg + 1'b1;
                    if (i_reg == (AW+1)'(N - 1))
                    begin
                        if (job_reg.cmd == isaac_pkg::CMD_NEXT)
                            st_next = isaac_pkg::ST_NRD;
                        else
                            st_next = isaac_pkg::ST_IDLE;
                    end
                    else
                        st_next = isaac_pkg::ST_GRD;
                end
                else
                begin
                    out_next = rrd;
                    ov_next = 1'b1;
                    st_next = isaac_pkg::ST_IDLE;
                end
            end
            default: st_next = isaac_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: rtl/isaac_random_generator.sv
`timescale 1ns / 1ps
// A next word from a live batch is read in ST_NRD and registered out in ST_NOUT.
// Per word a batch runs ST_GRD, ST_GRD2, ST_GWR, ST_GRD3, ST_GFIN and ST_NOUT,
// chaining reads through the registered state memory. Initialize scrambles the
// golden words, fills (two passes when seeded) and runs a batch. The sequencer
// takes one word at a time, a 2-entry job queue ahead. Reset: rst_n async low
// clears state, queue pointers, a, b, cnt, left, m_tvalid; memories keep data.
module isaac_random_generator
#(
    parameter int unsigned LOG2_WORDS = isaac_pkg::LOG2_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[1:0], seed_index[9:2], seed_word[41:10], use_seed[42], zero pad
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // random_word[31:0]
    output logic [31:0] m_tdata
);

    logic            q_valid, q_take;
    isaac_pkg::job_t q_job;

    isaac_front u_front
    (
        .clk, .rst_n, .s_tvalid, .s_tready, .s_tdata,
        .q_valid, .q_take, .q_job
    );

    isaac_back #(.LOG2_WORDS(LOG2_WORDS)) u_back
    (
        .clk, .rst_n, .q_valid, .q_take, .q_job,
        .m_tvalid, .m_tready, .m_tdata
    );

endmodule

// File: rtl/isaac_checker.sv
`timescale 1ns / 1ps

module isaac_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word dropped");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input word changed while waiting");

    a_ctrl_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({m_tvalid, s_tready}))
        else $error("handshake unknown");

    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output after reset");

endmodule

bind isaac_random_generator isaac_checker u_chk
(
    .clk, .rst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
);
